// File: hdl/ttts_pkg.sv
`default_nettype none
// ============================================================================
// Time-triggered task scheduler package
// Shared types, result codes and sizing constants for the scheduler core.
// ============================================================================
package ttts_pkg;

    // Sizing
    localparam int MAX_TASKS_DEF = 8;
    localparam int MAX_RESULTS   = 8;
    localparam int RES_CNT_W     = 4;
    localparam int TICK_W        = 64;
    localparam int PER_W         = 32;
    localparam int DIV_CNT_W     = 6;

    // Request types
    localparam logic REQ_REG  = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // Result kinds
    localparam logic [1:0] KIND_REG  = 2'd0;
    localparam logic [1:0] KIND_FIRE = 2'd1;
    localparam logic [1:0] KIND_IDLE = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK           = 2'd0;
    localparam logic [1:0] ST_NULL_HANDLER = 2'd1;
    localparam logic [1:0] ST_ZERO_PERIOD  = 2'd2;

    // Input word
    typedef struct packed {
        logic              req_type;
        logic [2:0]        slot;
        logic [PER_W-1:0]  period;
        logic [PER_W-1:0]  first_delay;
        logic              handler_present;
    } t_req;

    // Result word
    typedef struct packed {
        logic [1:0] result_kind;
        logic [2:0] task_slot;
        logic [1:0] status;
        logic       last;
    } t_result;

    // One task table entry
    typedef struct packed {
        logic [PER_W-1:0] period;
        logic [PER_W-1:0] delay;
    } t_entry;

    // Status returned by the modulo unit
    typedef struct packed {
        logic done;
        logic rem_zero;
    } t_div_stat;

endpackage
`default_nettype wire

// File: hdl/ttts_div.sv
`default_nettype none
// ============================================================================
// Serial modulo unit
// Restoring division of the 64-bit tick count by a 32-bit period, one
// quotient bit per cycle; reports whether the remainder is zero.
// ============================================================================
module ttts_div (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [ttts_pkg::TICK_W-1:0]  i_dividend,
    input  wire logic [ttts_pkg::PER_W-1:0]   i_divisor,
    output ttts_pkg::t_div_stat               o_stat
);
    import ttts_pkg::*;

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [TICK_W-1:0]    r_dvd, n_dvd;
    logic [PER_W-1:0]     r_dvs, n_dvs;
    logic [PER_W-1:0]     r_rem, n_rem;
    logic [PER_W:0]       rem_sh;
    logic [PER_W:0]       rem_sub;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    always_comb begin
        rem_sh  = {r_rem, r_dvd[TICK_W-1]};
        rem_sub = rem_sh - {1'b0, r_dvs};
    end

    // Step sequencing
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_dvd  = r_dvd;
        n_dvs  = r_dvs;
        n_rem  = r_rem;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_dvd  = i_dividend;
            n_dvs  = i_divisor;
            n_rem  = '0;
        end else if (r_busy) begin
            n_dvd = {r_dvd[TICK_W-2:0], 1'b0};
            n_cnt = r_cnt + 1'b1;
            if (rem_sh >= {1'b0, r_dvs}) begin
                n_rem = rem_sub[PER_W-1:0];
            end else begin
                n_rem = rem_sh[PER_W-1:0];
            end
            if (r_cnt == DIV_CNT_W'(TICK_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dvd <= n_dvd;
        r_dvs <= n_dvs;
        r_rem <= n_rem;
    end

    assign o_stat.done     = r_done;
    assign o_stat.rem_zero = (r_rem == '0);

endmodule
`default_nettype wire

// File: hdl/ttts_table.sv
`default_nettype none
// ============================================================================
// Task table
// Period and delay of every slot, one write port and one registered read.
// ============================================================================
module ttts_table #(
    parameter int DEPTH  = ttts_pkg::MAX_TASKS_DEF,
    parameter int ADDR_W = 3
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire ttts_pkg::t_entry  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output ttts_pkg::t_entry       o_rdata
);
    import ttts_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// File: hdl/time_triggered_task_scheduler_core.sv
`default_nettype none
// ============================================================================
// Time-triggered task scheduler core
// Priority-ordered task table with a global tick count. A registration word
// fills an empty slot; a tick word walks the slots and reports every task
// that fires on this tick.
// ============================================================================
//
// Channel   Direction  Handshake            Payload
// request   in         start high, busy low i_req    (t_req)
// result    out        o_strobe, one cycle  o_result (t_result)
//
// A registration's result follows in the next cycle and busy stays low.
// A tick walks all MAX_TASKS slots, reading (S_RD) and checking (S_CHK)
// each one, runs the serial modulo unit (S_DIV) for each valid slot whose
// delay has run out, and closes the tick in S_END.
// Reset is synchronous and clears the valid marks and the tick count; the
// table contents need no clearing. The receiver cannot stall the results.
// ============================================================================
module time_triggered_task_scheduler_core #(
    parameter int MAX_TASKS = ttts_pkg::MAX_TASKS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire ttts_pkg::t_req i_req,
    output logic             o_strobe,
    output ttts_pkg::t_result o_result
);
    import ttts_pkg::*;

    localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_CHK  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_END  = 3'd4;

    logic [2:0]           r_state, n_state;
    logic [MAX_TASKS-1:0] r_valid, n_valid;
    logic [TICK_W-1:0]    r_tick, n_tick;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic                 r_pend, n_pend;
    logic [2:0]           r_pend_slot, n_pend_slot;
    logic [RES_CNT_W-1:0] r_nrep, n_nrep;
    logic                 r_strobe, n_strobe;
    t_result              r_res, n_res;

    logic                 accept;
    logic                 slot_in_range;
    logic [IDX_W-1:0]     reg_idx;
    logic                 tbl_we;
    logic [IDX_W-1:0]     tbl_waddr;
    t_entry               tbl_wdata;
    t_entry               tbl_rdata;
    logic                 div_start;
    t_div_stat            div_stat;
    logic                 last_slot;

    // Shared table and modulo unit
    ttts_table #(
        .DEPTH  (MAX_TASKS),
        .ADDR_W (IDX_W)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (tbl_wdata),
        .i_raddr (r_idx),
        .o_rdata (tbl_rdata)
    );

    ttts_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_tick),
        .i_divisor  (tbl_rdata.period),
        .o_stat     (div_stat)
    );

    assign busy          = (r_state != S_IDLE);
    assign accept        = start && !busy;
    assign slot_in_range = (7'(i_req.slot) < 7'(MAX_TASKS));
    assign reg_idx       = IDX_W'(i_req.slot);
    assign last_slot     = (r_idx == IDX_W'(MAX_TASKS - 1));

    // Sequencer and table update
    always_comb begin
        n_state     = r_state;
        n_valid     = r_valid;
        n_tick      = r_tick;
        n_idx       = r_idx;
        n_pend      = r_pend;
        n_pend_slot = r_pend_slot;
        n_nrep      = r_nrep;
        n_strobe    = 1'b0;
        n_res       = r_res;
        tbl_we      = 1'b0;
        tbl_waddr   = r_idx;
        tbl_wdata   = tbl_rdata;
        div_start   = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_req.req_type == REQ_REG) begin
                        // Registration answers at once.
                        n_strobe          = 1'b1;
                        n_res.result_kind = KIND_REG;
                        n_res.task_slot   = i_req.slot;
                        n_res.last        = 1'b1;
                        if (!i_req.handler_present) begin
                            n_res.status = ST_NULL_HANDLER;
                        end else if (i_req.period == '0) begin
                            n_res.status = ST_ZERO_PERIOD;
                        end else begin
                            n_res.status = ST_OK;
                            if (slot_in_range && !r_valid[reg_idx]) begin
                                n_valid[reg_idx] = 1'b1;
                                tbl_we           = 1'b1;
                                tbl_waddr        = reg_idx;
                                tbl_wdata.period = i_req.period;
                                tbl_wdata.delay  = i_req.first_delay;
                            end
                        end
                    end else begin
                        n_idx   = '0;
                        n_pend  = 1'b0;
                        n_nrep  = '0;
                        n_state = S_RD;
                    end
                end
            end

            S_RD: begin
                // Table read of the current slot lands at this edge.
                n_state = S_CHK;
            end

            S_CHK: begin
                if (r_valid[r_idx] && tbl_rdata.delay == '0) begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end else begin
                    if (r_valid[r_idx]) begin
                        tbl_we          = 1'b1;
                        tbl_wdata.delay = tbl_rdata.delay - 1'b1;
                    end
                    if (last_slot) begin
                        n_state = S_END;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_RD;
                    end
                end
            end

            S_DIV: begin
                if (div_stat.done) begin
                    // A fire is held back one step so the final one can carry last.
                    if (div_stat.rem_zero && r_nrep < RES_CNT_W'(MAX_RESULTS)) begin
                        if (r_pend) begin
                            n_strobe          = 1'b1;
                            n_res.result_kind = KIND_FIRE;
                            n_res.task_slot   = r_pend_slot;
                            n_res.status      = ST_OK;
                            n_res.last        = 1'b0;
                        end
                        n_pend      = 1'b1;
                        n_pend_slot = 3'(r_idx);
                        n_nrep      = r_nrep + 1'b1;
                    end
                    if (last_slot) begin
                        n_state = S_END;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_RD;
                    end
                end
            end

            S_END: begin
                // Close the tick with the held fire or an empty marker.
                n_strobe     = 1'b1;
                n_res.status = ST_OK;
                n_res.last   = 1'b1;
                if (r_pend) begin
                    n_res.result_kind = KIND_FIRE;
                    n_res.task_slot   = r_pend_slot;
                end else begin
                    n_res.result_kind = KIND_IDLE;
                    n_res.task_slot   = 3'd0;
                end
                n_tick  = r_tick + 1'b1;
                n_state = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= '0;
            r_tick   <= '0;
            r_idx    <= '0;
            r_pend   <= 1'b0;
            r_nrep   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_valid  <= n_valid;
            r_tick   <= n_tick;
            r_idx    <= n_idx;
            r_pend   <= n_pend;
            r_nrep   <= n_nrep;
            r_strobe <= n_strobe;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_pend_slot <= n_pend_slot;
        r_res       <= n_res;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_res;

`ifndef SYNTHESIS
    // The final word of an item appears only once the block is idle again.
    a_last_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (busy == !o_result.last))
        else $error("last flag does not match sequencer state");

    // An empty marker is always the single, final word of its tick.
    a_idle_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.result_kind == KIND_IDLE) |->
            (o_result.last && o_result.task_slot == 3'd0 && $past(r_state) == S_END))
        else $error("empty marker malformed");

    // The tick count moves only when a tick closes.
    a_tick_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tick != $past(r_tick)) |-> (o_strobe && o_result.last &&
            o_result.result_kind != KIND_REG))
        else $error("tick count changed outside a tick");
`endif

endmodule
`default_nettype wire

// File: tb/time_triggered_task_scheduler_core_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// Time-triggered task scheduler core testbench
// Drives registration and tick words through the start/busy handshake and
// checks every result word against the directed want or a local prediction
// of the task table and the tick count. A short table of directed words
// comes first, followed by random words with random gaps between them.
// ============================================================================
module time_triggered_task_scheduler_core_tb;

    import ttts_pkg::*;

    localparam int          TASKS      = MAX_TASKS_DEF;
    localparam logic [31:0] PMAX       = 32'hFFFF_FFFF;
    localparam t_result     NO_RESULT  = '0;
    localparam int          RAND_WORDS = 410;
    localparam int          DRAIN_CYC  = 600;

    // One row of the directed table; want is used only where typed is set.
    typedef struct {
        t_req    word;
        bit      typed;
        t_result want;
    } t_step_row;

    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start   = 1'b0;
    t_req    i_req   = '0;
    logic    busy;
    logic    o_strobe;
    t_result o_result;

    // Local copy of the task table and the tick count.
    logic        task_valid  [TASKS];
    logic [31:0] task_period [TASKS];
    logic [31:0] task_delay  [TASKS];
    logic [63:0] tick_cnt;

    t_result word_results [$];
    t_result due_results  [$];
    int      mismatch_count = 0;
    bit      no_idle        = 1'b0;

    // The directed words. The table starts empty and ends fully occupied, the
    // last tick firing all eight slots at once.
    t_step_row directed_steps [21] = '{
        '{'{REQ_TICK, 3'd7, PMAX, PMAX, 1'b1}, 1'b1,
          '{KIND_IDLE, 3'd0, ST_OK, 1'b1}},
        '{'{REQ_REG, 3'd0, 32'd5, 32'd0, 1'b0}, 1'b1,
          '{KIND_REG, 3'd0, ST_NULL_HANDLER, 1'b1}},
        '{'{REQ_REG, 3'd0, 32'd0, 32'd0, 1'b0}, 1'b1,
          '{KIND_REG, 3'd0, ST_NULL_HANDLER, 1'b1}},
        '{'{REQ_REG, 3'd0, 32'd0, 32'd9, 1'b1}, 1'b1,
          '{KIND_REG, 3'd0, ST_ZERO_PERIOD, 1'b1}},
        '{'{REQ_REG, 3'd7, PMAX, PMAX, 1'b0}, 1'b1,
          '{KIND_REG, 3'd7, ST_NULL_HANDLER, 1'b1}},
        '{'{REQ_REG, 3'd0, 32'd2, 32'd0, 1'b1}, 1'b1,
          '{KIND_REG, 3'd0, ST_OK, 1'b1}},
        '{'{REQ_REG, 3'd0, 32'd0, 32'd0, 1'b1}, 1'b1,
          '{KIND_REG, 3'd0, ST_ZERO_PERIOD, 1'b1}},
        '{'{REQ_REG, 3'd0, PMAX, PMAX, 1'b1}, 1'b1,
          '{KIND_REG, 3'd0, ST_OK, 1'b1}},
        '{'{REQ_TICK, 3'd0, 32'd0, 32'd0, 1'b0}, 1'b0, NO_RESULT},
        '{'{REQ_TICK, 3'd2, 32'd0, 32'd0, 1'b0}, 1'b0, NO_RESULT},
        '{'{REQ_REG, 3'd1, 32'd3, 32'd2, 1'b1}, 1'b0, NO_RESULT},
        '{'{REQ_REG, 3'd7, 32'd6, 32'd0, 1'b1}, 1'b0, NO_RESULT},
        '{'{REQ_REG, 3'd2, 32'd2, 32'd0, 1'b1}, 1'b0, NO_RESULT},
        '{'{REQ_REG, 3'd3, 32'd3, 32'd1, 1'b1}, 1'b0, NO_RESULT},
        '{'{REQ_REG, 3'd4, 32'd6, 32'd0, 1'b1}, 1'b0, NO_RESULT},
        '{'{REQ_REG, 3'd5, 32'd2, 32'd2, 1'b1}, 1'b0, NO_RESULT},
        '{'{REQ_REG, 3'd6, 32'd3, 32'd0, 1'b1}, 1'b0, NO_RESULT},
        '{'{REQ_TICK, 3'd5, 32'd0, 32'd1, 1'b1}, 1'b0, NO_RESULT},
        '{'{REQ_TICK, 3'd0, PMAX, 32'd0, 1'b0}, 1'b0, NO_RESULT},
        '{'{REQ_TICK, 3'd3, 32'd7, PMAX, 1'b1}, 1'b0, NO_RESULT},
        '{'{REQ_TICK, 3'd1, 32'd0, 32'd0, 1'b0}, 1'b0, NO_RESULT}
    };

    time_triggered_task_scheduler_core #(
        .MAX_TASKS (TASKS)
    ) i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_req    (i_req),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    always #5 i_clk = ~i_clk;

    // Works out the result words of one accepted word into word_results and
    // moves the local table and tick count on.
    function automatic void schedule_word(input t_req w);
        t_result r;
        int      fired;
        word_results.delete();
        r     = '0;
        fired = 0;
        if (w.req_type == REQ_REG) begin
            r.result_kind = KIND_REG;
            r.task_slot   = w.slot;
            r.status      = ST_OK;
            r.last        = 1'b1;
            // A null handler is checked before a zero period.
            if (!w.handler_present) begin
                r.status = ST_NULL_HANDLER;
            end else if (w.period == '0) begin
                r.status = ST_ZERO_PERIOD;
            end else if (int'(w.slot) < TASKS && !task_valid[w.slot]) begin
                task_valid[w.slot]  = 1'b1;
                task_period[w.slot] = w.period;
                task_delay[w.slot]  = w.first_delay;
            end
            word_results.push_back(r);
        end else begin
            // Walk the slots in priority order.
            for (int i = 0; i < TASKS; i++) begin
                if (task_valid[i]) begin
                    if (task_delay[i] == '0) begin
                        if (task_period[i] != '0 && (tick_cnt % {32'd0, task_period[i]}) == '0
                            && fired < MAX_RESULTS) begin
                            r.result_kind = KIND_FIRE;
                            r.task_slot   = i[2:0];
                            r.status      = ST_OK;
                            r.last        = 1'b0;
                            word_results.push_back(r);
                            fired++;
                        end
                    end else begin
                        task_delay[i] = task_delay[i] - 32'd1;
                    end
                end
            end
            if (fired == 0) begin
                r.result_kind = KIND_IDLE;
                r.task_slot   = 3'd0;
                r.status      = ST_OK;
                r.last        = 1'b1;
                word_results.push_back(r);
            end else begin
                word_results[word_results.size() - 1].last = 1'b1;
            end
            tick_cnt = tick_cnt + 64'd1;
        end
    endfunction

    // Number of idle cycles before the next word; no gaps during a burst.
    function automatic int draw_gap();
        return no_idle ? 0 : int'($urandom_range(0, 12));
    endfunction

    // Offers one word after a gap, waits for it to be taken and records what
    // it should produce.
    task automatic send_word(input t_req w, input int gap, input bit typed,
                             input t_result want);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= w;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        schedule_word(w);
        if (typed) begin
            due_results.push_back(want);
        end else begin
            foreach (word_results[k]) due_results.push_back(word_results[k]);
        end
    endtask

    // Withdraws the offer so the last word is not taken again, then waits
    // until every expected result word has arrived.
    task automatic wait_drained();
        if (start) start <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
    endtask

    // Compare every result word with the oldest expected one.
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_strobe) begin
            if (due_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("%0t: unexpected result: kind %0d slot %0d status %0d last %0d",
                             $time, o_result.result_kind, o_result.task_slot,
                             o_result.status, o_result.last);
                end
            end else begin
                want = due_results.pop_front();
                if (o_result.result_kind !== want.result_kind ||
                    o_result.task_slot !== want.task_slot ||
                    o_result.status !== want.status ||
                    o_result.last !== want.last) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("%0t: mismatch: expected kind %0d slot %0d status %0d last %0d,",
                                 $time, want.result_kind, want.task_slot, want.status,
                                 want.last);
                        $display("    got kind %0d slot %0d status %0d last %0d",
                                 o_result.result_kind, o_result.task_slot,
                                 o_result.status, o_result.last);
                    end
                end
            end
        end
    end

    // Main sequence: reset, directed table, random words, drain.
    initial begin : stimulus
        t_req w;
        int   pick;
        foreach (task_valid[i]) begin
            task_valid[i]  = 1'b0;
            task_period[i] = '0;
            task_delay[i]  = '0;
        end
        tick_cnt = '0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_steps[n]) begin
            send_word(directed_steps[n].word, draw_gap(), directed_steps[n].typed,
                      directed_steps[n].want);
        end
        // Let the directed words finish before the random part starts.
        wait_drained();

        // The table is full by now, so registrations only report a status;
        // ticks carry random content in the fields they ignore.
        for (int n = 0; n < RAND_WORDS; n++) begin
            if (n % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 49) == 0) wait_drained();
            w.req_type        = REQ_REG;
            w.slot            = 3'($urandom_range(0, 7));
            w.period          = $urandom;
            w.first_delay     = $urandom;
            w.handler_present = ($urandom_range(0, 4) != 0);
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                w.req_type        = REQ_TICK;
                w.handler_present = 1'($urandom_range(0, 1));
            end else if (pick < 60) begin
                w.period = '0;
            end
            send_word(w, draw_gap(), 1'b0, NO_RESULT);
        end

        wait_drained();
        repeat (DRAIN_CYC) @(posedge i_clk);

        if (mismatch_count == 0 && due_results.size() == 0) begin
            $display("** time_triggered_task_scheduler_core: PASSED **");
        end else begin
            $display("** time_triggered_task_scheduler_core: FAILED **");
        end
        $finish;
    end

    // Hard stop in case the block hangs.
    initial begin : watchdog
        #10_000_000;
        $display("** time_triggered_task_scheduler_core: FAILED **");
        $finish;
    end

endmodule

// File: files.f
hdl/ttts_pkg.sv
hdl/ttts_div.sv
hdl/ttts_table.sv
hdl/time_triggered_task_scheduler_core.sv
tb/time_triggered_task_scheduler_core_tb.sv
